FILE: rtl/abwd_pkg.sv
// abwd_pkg: types, constants and the constant key-schedule ROM for the
// archive block word decryptor. No dependencies.
`default_nettype none

package abwd_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned RomDepth = 256;

	localparam logic [31:0] GenStart = 32'h0010_0001;
	localparam logic [31:0] GenMul = 32'd125;
	localparam logic [31:0] GenMod = 32'h002A_AAAB;
	localparam int unsigned RomSegment = 4;
	localparam int unsigned SegCount = 5;

	localparam logic [31:0] SeedInit = 32'hEEEE_EEEE;
	localparam logic [31:0] KeyAdd = 32'h1111_1111;
	localparam int unsigned KeyShl = 21;
	localparam int unsigned KeyShr = 11;

	typedef struct packed {
		logic [WordW-1:0] cipher_word;
		logic             last_word;
	} word_t;

	typedef struct packed {
		logic [WordW-1:0] plain_word;
		logic             block_end;
	} result_t;

	typedef logic [WordW-1:0] rom_t [RomDepth];

	// LCG step; the operands stay below 2^32 since s < GenMod.
	function automatic logic [31:0] gen_next(input logic [31:0] s);
		logic [31:0] t;
		t = s * GenMul + 32'd3;
		return t % GenMod;
	endfunction

	// Crypt table segment, evaluated at elaboration only.
	function automatic rom_t build_rom();
		rom_t        r;
		logic [31:0] s;
		logic [15:0] hi;
		s = GenStart;
		hi = '0;
		for (int row = 0; row < RomDepth; row++) begin
			for (int seg = 0; seg < SegCount; seg++) begin
				s = gen_next(s);
				hi = s[15:0];
				s = gen_next(s);
				if (seg == RomSegment) begin
					r[row] = {hi, s[15:0]};
				end
			end
		end
		return r;
	endfunction

	localparam rom_t CryptRom = build_rom();

endpackage

`default_nettype wire

FILE: rtl/archive_block_word_decrypt_core.sv
// Archive block word decryptor, top level.
// Uses abwd_pkg (payload structs, constants, crypt ROM).
`default_nettype none

// Usage
//   word channel   (word_valid / word_stall / word): one encrypted word per
//                  request, last_word closes the block.
//   result channel (result_valid / result_stall / result): one plaintext word
//                  per request, block_end copies last_word.
//   cfg channel    (cfg_valid / cfg_ready / cfg_data): block_key, taken at the
//                  first word of each block. cfg_ready is always high; write
//                  only while no word is in flight.
// Path: a word accepted on the word channel passes the input register,
//   then the result register on its way to the result channel.
// Throughput: one word per cycle while result_stall is low. The key and seed
//   recurrence is closed combinationally between the input and result registers.
// Stall: while result_stall holds a pending result, one more word can be
//   taken into the input register; after that word_stall rises.
// Reset: arst_n clears all valids, sets block_key to 0 and arms the block
//   start, so the first word loads the key and the seed 0xEEEEEEEE.
module archive_block_word_decrypt_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 word_valid,
	output logic                word_stall,
	input  abwd_pkg::word_t     word,
	output logic                result_valid,
	input  wire                 result_stall,
	output abwd_pkg::result_t   result,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [31:0]         cfg_data
);
	import abwd_pkg::*;

	logic        valid_s1;
	word_t       word_s1;
	logic        advance;
	logic        proc;

	logic [31:0] block_key_q;
	logic [31:0] key_q;
	logic [31:0] seed_q;
	logic        pending_q;

	logic [31:0] key;
	logic [31:0] seed;
	logic [31:0] plain;
	logic [31:0] key_next;
	logic [31:0] seed_next;

	assign cfg_ready = 1'b1;

	assign advance = !result_valid || !result_stall;
	assign proc = valid_s1 && advance;
	assign word_stall = valid_s1 && !advance;

	always_comb begin
		key = pending_q ? block_key_q : key_q;
		seed = (pending_q ? SeedInit : seed_q) + CryptRom[key[7:0]];
		plain = word_s1.cipher_word ^ (key + seed);
		key_next = ((~key << KeyShl) + KeyAdd) | (key >> KeyShr);
		seed_next = plain + seed + (seed << 5) + 32'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid <= 1'b0;
			block_key_q <= '0;
			key_q <= '0;
			seed_q <= SeedInit;
			pending_q <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				block_key_q <= cfg_data;
			end
			if (!word_stall) begin
				valid_s1 <= word_valid;
			end
			if (advance) begin
				result_valid <= valid_s1;
			end
			if (proc) begin
				key_q <= key_next;
				seed_q <= seed_next;
				pending_q <= word_s1.last_word;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (word_valid && !word_stall) begin
			word_s1 <= word;
		end
		if (proc) begin
			result.plain_word <= plain;
			result.block_end <= word_s1.last_word;
		end
	end

	a_proc_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> result_valid)
		else $error("processed word did not produce a result");

	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && word_s1.last_word) |=> pending_q)
		else $error("block start not armed after last word");

	a_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !word_s1.last_word) |=> !pending_q)
		else $error("block start armed in the middle of a block");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		word_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled with room in the pipe");

	a_end_matches: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> (result.block_end == $past(word_s1.last_word)))
		else $error("block_end does not follow last_word");

endmodule

`default_nettype wire

FILE: tb/archive_block_word_decrypt_checker.sv
// Checker for archive_block_word_decrypt_core: watches the cfg, word and result
// channels, predicts each plaintext word and compares. Depends on abwd_pkg.
`timescale 1ns / 1ps

module archive_block_word_decrypt_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 word_valid,
	input  wire                 word_stall,
	input  abwd_pkg::word_t     word,
	input  wire                 result_valid,
	input  wire                 result_stall,
	input  abwd_pkg::result_t   result,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire  [31:0]         cfg_data,
	output int unsigned         errors,
	output int unsigned         pending
);
	import abwd_pkg::*;

	logic [31:0] crypt_rom [RomDepth];
	logic [31:0] key_reg;
	logic [31:0] cur_key;
	logic [31:0] cur_seed;
	logic        start_armed;
	logic [31:0] k, s, p;
	result_t     want;
	result_t     plain_fifo [$];

	initial begin
		logic [31:0] lcg;
		logic [15:0] hi;
		lcg = GenStart;
		for (int row = 0; row < RomDepth; row++) begin
			for (int seg = 0; seg < SegCount; seg++) begin
				lcg = (lcg * GenMul + 32'd3) % GenMod;
				hi = lcg[15:0];
				lcg = (lcg * GenMul + 32'd3) % GenMod;
				if (seg == RomSegment) begin
					crypt_rom[row] = {hi, lcg[15:0]};
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			key_reg = '0;
			cur_key = '0;
			cur_seed = SeedInit;
			start_armed = 1'b1;
			plain_fifo.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_reg = cfg_data;
			end
			if (result_valid && !result_stall) begin
				if (plain_fifo.size() == 0) begin
					$error("result with no request outstanding: plain_word %h block_end %b",
						result.plain_word, result.block_end);
					errors++;
				end else begin
					want = plain_fifo.pop_front();
					if (result.plain_word !== want.plain_word) begin
						$error("plain_word: expected %h, got %h", want.plain_word,
							result.plain_word);
						errors++;
					end
					if (result.block_end !== want.block_end) begin
						$error("block_end: expected %b, got %b", want.block_end,
							result.block_end);
						errors++;
					end
				end
			end
			if (word_valid && !word_stall) begin
				// first word of a block reloads key and seed
				if (start_armed) begin
					cur_key = key_reg;
					cur_seed = SeedInit;
				end
				k = cur_key;
				s = cur_seed + crypt_rom[k[7:0]];
				p = word.cipher_word ^ (k + s);
				cur_key = ((~k << KeyShl) + KeyAdd) | (k >> KeyShr);
				cur_seed = p + s + (s << 5) + 32'd3;
				start_armed = word.last_word;
				plain_fifo.push_back('{plain_word: p, block_end: word.last_word});
			end
		end
		pending = plain_fifo.size();
	end

endmodule

FILE: tb/tb_archive_block_word_decrypt_core.sv
// Testbench top for archive_block_word_decrypt_core: clock, reset, stimulus and
// verdict. Depends on abwd_pkg and archive_block_word_decrypt_checker.
`timescale 1ns / 1ps

module tb_archive_block_word_decrypt_core;
	import abwd_pkg::*;

	localparam int unsigned CycleLimit = 400_000;
	localparam int unsigned PhaseWords = 350;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        word_valid = 1'b0;
	word_t       word = '0;
	logic        result_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [31:0] cfg_data = '0;
	wire         word_stall;
	wire         result_valid;
	wire         cfg_ready;
	result_t     result;

	int unsigned errors;
	int unsigned pending;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;

	archive_block_word_decrypt_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word         (word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	archive_block_word_decrypt_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word         (word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Returns at the edge that accepts the request.
	task automatic send_word(input logic [31:0] cipher, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			word_valid <= 1'b0;
			@(posedge clk);
		end
		word_valid <= 1'b1;
		word <= '{cipher_word: cipher, last_word: last};
		do @(negedge clk); while (word_stall);
		@(posedge clk);
	endtask

	// Stop sending and wait for every predicted word to come back.
	task automatic drain();
		word_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_key(input logic [31:0] key);
		cfg_valid <= 1'b1;
		cfg_data <= key;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] key, input int unsigned sidle,
		input int unsigned rstall);
		int unsigned sent;
		int unsigned len;
		bit          held;
		drain();
		write_key(key);
		idle_pct = sidle;
		stall_pct = rstall;
		sent = 0;
		held = 1'b0;
		while (sent < PhaseWords) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
			// phase may end mid-block; the next key then waits for the next block
			for (int i = 0; i < len && sent < PhaseWords; i++) begin
				send_word($urandom, i == len - 1);
				sent++;
			end
			if (!held && sent >= PhaseWords / 2) begin
				held = 1'b1;
				drain();
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key of zero, single-word block first
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h5A5A_5A5A, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		drain();
		write_key(32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h8000_0001, 1'b1);
		send_word(32'h0000_0000, 1'b0);
		// key changed mid-block: old key runs to the block end
		drain();
		write_key(32'h0000_0100);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0F0F_F0F0, 1'b1);
		send_word(32'h1234_5678, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		drain();
		write_key(32'h0000_00FF);
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'hA5A5_A5A5, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		drain();
		write_key(32'h8000_0000);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h0000_0001, 1'b1);

		run_phase(32'h0000_0000, 0, 0);
		run_phase(32'hFFFF_FFFF, 81, 0);
		run_phase($urandom, 0, 81);
		run_phase($urandom, 27, 27);

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/abwd_pkg.sv
rtl/archive_block_word_decrypt_core.sv
tb/archive_block_word_decrypt_checker.sv
tb/tb_archive_block_word_decrypt_core.sv
